/* hdl/bia_pkg.sv */
// Shared types, constants and codes of the bitmap id allocator.
package bia_pkg;

  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int ID_W          = 10;
  localparam int DEF_MAX_WORDS = 32;

  localparam logic [ID_W-1:0] TOTAL_IDS_RST = ID_W'(1023);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [ID_W-1:0] id_in;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] id_out;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    ld_init;
    logic    ld_alloc;
    logic    ld_free;
    logic    adv;
    logic    chk;
    logic    wr_init;
    logic    wr_alloc;
    logic    wr_free;
    logic    rsp_ld;
    status_e rsp_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic last;
    logic free_oob;
    logic init_last;
  } sts_t;

endpackage

/* hdl/bia_ctrl.sv */
// Sequencer of the bitmap id allocator: decodes items and steps the datapath.
module bia_ctrl import bia_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] opcode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_INIT_WR
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (opcode_i)
            OP_INIT: begin
              cmd_o.ld_init = 1'b1;
              state_d       = S_INIT_WR;
            end
            OP_ALLOC: begin
              cmd_o.ld_alloc = 1'b1;
              state_d        = S_ALLOC_RD;
            end
            OP_FREE: begin
              if (sts_i.free_oob) begin
                cmd_o.rsp_ld     = 1'b1;
                cmd_o.rsp_status = STS_RANGE;
                done_d           = 1'b1;
              end else begin
                cmd_o.ld_free = 1'b1;
                state_d       = S_FREE_RD;
              end
            end
            default: begin
              // unused opcode: no state change, plain ok result
              cmd_o.rsp_ld     = 1'b1;
              cmd_o.rsp_status = STS_OK;
              done_d           = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        cmd_o.adv = 1'b1;
        state_d   = S_ALLOC_SCAN;
      end
      S_ALLOC_SCAN: begin
        cmd_o.adv = 1'b1;
        cmd_o.chk = 1'b1;
        if (sts_i.hit) begin
          cmd_o.wr_alloc   = 1'b1;
          cmd_o.rsp_ld     = 1'b1;
          cmd_o.rsp_status = STS_OK;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end else if (sts_i.last) begin
          cmd_o.rsp_ld     = 1'b1;
          cmd_o.rsp_status = STS_EMPTY;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_FREE_RD: begin
        state_d = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd_o.wr_free    = 1'b1;
        cmd_o.rsp_ld     = 1'b1;
        cmd_o.rsp_status = STS_OK;
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end
      S_INIT_WR: begin
        cmd_o.wr_init = 1'b1;
        if (sts_i.init_last) begin
          cmd_o.rsp_ld     = 1'b1;
          cmd_o.rsp_status = STS_OK;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result strobe while still working");

  a_alloc_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ALLOC_RD |-> $past(state_q == S_IDLE && start_i && opcode_i == OP_ALLOC))
    else $error("allocate scan entered without an allocate item");

  a_free_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FREE_WR |-> $past(state_q == S_FREE_RD))
    else $error("free write-back without its read");

endmodule

/* hdl/bia_dpath.sv */
// Datapath of the bitmap id allocator: bitmap memory, scan pointers, result register.
module bia_dpath import bia_pkg::*; #(
  parameter int MaxWords = DEF_MAX_WORDS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  req_t            req_i,
  input  logic [ID_W-1:0] total_ids_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output rsp_t            rsp_o
);

  localparam int AddrW = $clog2(MaxWords);
  localparam int WcW   = $clog2(MaxWords + 1);
  localparam int IdWW  = ID_W - BIT_W;
  localparam int NW    = IdWW + 1;
  localparam int CmpW  = (IdWW > WcW) ? IdWW : WcW;

  logic [WORD_BITS-1:0] mem_q [MaxWords];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 mem_valid_q;

  logic [WcW-1:0]   word_count_q;
  logic [AddrW-1:0] search_start_q;
  logic [AddrW-1:0] scan_idx_q;
  logic [AddrW-1:0] chk_idx_q;
  logic [WcW-1:0]   left_q;
  logic [ID_W-1:0]  rem_q;
  logic [BIT_W-1:0] bit_q;
  rsp_t             rsp_q;

  logic [AddrW-1:0]     wc_last;
  logic [AddrW-1:0]     scan_next;
  logic [AddrW-1:0]     ss_next;
  logic [IdWW-1:0]      id_word;
  logic [NW-1:0]        n_raw;
  logic [WcW-1:0]       n_words;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] low_oh;
  logic [WORD_BITS-1:0] alloc_word;
  logic [WORD_BITS-1:0] free_word;
  logic [WORD_BITS-1:0] init_word;
  logic [BIT_W-1:0]     bit_idx;
  logic [ID_W-1:0]      alloc_id;
  logic                 mem_we;
  logic [AddrW-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  assign wc_last   = AddrW'(word_count_q - WcW'(1));
  assign scan_next = (scan_idx_q == wc_last) ? '0 : scan_idx_q + AddrW'(1);
  assign ss_next   = (search_start_q == wc_last) ? '0 : search_start_q + AddrW'(1);

  assign id_word = req_i.id_in[ID_W-1:BIT_W];
  assign n_raw   = NW'(total_ids_i[ID_W-1:BIT_W]) + NW'(1);
  assign n_words = (int'(n_raw) > MaxWords) ? WcW'(MaxWords) : WcW'(n_raw);

  // until the first write after reset, every word reads as all allocated
  assign rd_word    = rd_data_q & {WORD_BITS{mem_valid_q}};
  assign low_oh     = rd_word & (~rd_word + WORD_BITS'(1));
  assign alloc_word = rd_word & ~low_oh;
  assign free_word  = rd_word | (WORD_BITS'(1) << bit_q);
  assign init_word  = (rem_q >= ID_W'(WORD_BITS)) ? '1 :
                      ~({WORD_BITS{1'b1}} << rem_q[BIT_W-1:0]);

  always_comb begin
    bit_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (low_oh[b]) bit_idx = bit_idx | BIT_W'(b);
    end
  end

  assign alloc_id = ID_W'({chk_idx_q, bit_idx});

  always_comb begin
    mem_we  = cmd_i.wr_init | cmd_i.wr_alloc | cmd_i.wr_free;
    wr_addr = cmd_i.wr_init ? scan_idx_q : chk_idx_q;
    if (cmd_i.wr_init) begin
      wr_data = init_word;
    end else if (cmd_i.wr_alloc) begin
      wr_data = alloc_word;
    end else begin
      wr_data = free_word;
    end
  end

  assign sts_o.hit       = (rd_word != '0);
  assign sts_o.last      = (left_q == WcW'(1));
  assign sts_o.free_oob  = (CmpW'(id_word) >= CmpW'(word_count_q));
  assign sts_o.init_last = (scan_idx_q == wc_last);

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_data;
    rd_data_q <= mem_q[scan_idx_q];
    chk_idx_q <= scan_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q   <= WcW'(1);
      search_start_q <= '0;
      mem_valid_q    <= 1'b0;
    end else begin
      if (mem_we) mem_valid_q <= 1'b1;
      if (cmd_i.ld_init) begin
        word_count_q   <= n_words;
        search_start_q <= '0;
      end else if (cmd_i.wr_alloc && alloc_word == '0) begin
        search_start_q <= ss_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_init) begin
      scan_idx_q <= '0;
      rem_q      <= total_ids_i;
    end else if (cmd_i.ld_alloc) begin
      scan_idx_q <= search_start_q;
      left_q     <= word_count_q;
    end else if (cmd_i.ld_free) begin
      scan_idx_q <= AddrW'(id_word);
      bit_q      <= req_i.id_in[BIT_W-1:0];
    end else if (cmd_i.wr_init) begin
      scan_idx_q <= scan_idx_q + AddrW'(1);
      rem_q      <= (rem_q > ID_W'(WORD_BITS)) ? rem_q - ID_W'(WORD_BITS) : '0;
    end else if (cmd_i.adv) begin
      scan_idx_q <= scan_next;
    end
    if (cmd_i.chk) left_q <= left_q - WcW'(1);
    if (cmd_i.rsp_ld) begin
      rsp_q.status <= cmd_i.rsp_status;
      rsp_q.id_out <= cmd_i.wr_alloc ? alloc_id : '0;
    end
  end

  assign rsp_o = rsp_q;

  a_ss_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WcW'(search_start_q) < word_count_q)
    else $error("search start beyond word count");

  a_wc_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_count_q >= WcW'(1) && int'(word_count_q) <= MaxWords)
    else $error("word count out of bounds");

  a_alloc_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_alloc |-> $countones(rd_word ^ alloc_word) == 1)
    else $error("allocate write-back must clear exactly one bit");

endmodule

/* hdl/bitmap_id_allocator_top.sv */
// Top level of the bitmap id allocator: config register, sequencer and datapath.
//
//  channel  | signals                              | direction | transfer
//  ---------+--------------------------------------+-----------+-----------------------
//  command  | start, req_i; busy (out)             | in        | start && !busy
//  result   | done_o, rsp_o                        | out       | done_o, one cycle
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i | in        | cfg_valid_i && ready
//
//  Allocate scans from the search start, examining up to word count words in turn:
//  the bitmap memory has one read port and the scan reads one word per cycle.
//  Free reads the id's word and writes it back; an out-of-range id gets a range status.
//  Init writes one bitmap word per cycle up to the word count. Unused opcode: ok status.
//  After reset every id is allocated and the word count is 1; no clearing pass.
//  The result strobe lasts one cycle and cannot be held off by the receiver.
module bitmap_id_allocator_top import bia_pkg::*; #(
  parameter int MaxWords = DEF_MAX_WORDS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  req_t            req_i,
  output logic            done_o,
  output rsp_t            rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [ID_W-1:0] cfg_data_i
);

  logic [ID_W-1:0] total_ids_q;
  cmd_t            cmd;
  sts_t            sts;
  logic            busy_int;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_ids_q <= TOTAL_IDS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      total_ids_q <= cfg_data_i;
    end
  end

  bia_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start && !busy_int),
    .opcode_i (req_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_int),
    .done_o   (done_o)
  );

  bia_dpath #(
    .MaxWords (MaxWords)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .total_ids_i (total_ids_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

  assign busy = busy_int;

endmodule
